// ----- src/ftts_pkg.sv -----
// Package with shared types and constants for the fixed-timestep tick scheduler.
`default_nettype none

package ftts_pkg;

    // Field widths.
    localparam int PERIOD_W = 20;
    localparam int FRAME_W  = 20;
    localparam int SCALE_W  = 11;
    localparam int CNT_W    = 6;
    localparam int ACC_W    = 22;
    localparam int STEP_W   = 22;
    localparam int SIM_W    = 48;
    localparam int ALPHA_W  = 17;
    localparam int DROP_W   = 21;
    localparam int CIDX_W   = 8;
    localparam int CDATA_W  = 20;

    // Most ticks in one frame and saturation level of pending step requests.
    localparam logic [CNT_W:0] MAX_TICKS = 7'd32;

    // Largest time scale, 4.0 in Q3.8.
    localparam logic [SCALE_W-1:0] SCALE_MAX = 11'd1024;

    // Register reset values.
    localparam logic [PERIOD_W-1:0] RST_TICK_PERIOD = 20'd16667;
    localparam logic [CNT_W-1:0]    RST_MAX_CATCHUP = 6'd8;
    localparam logic [FRAME_W-1:0]  RST_MAX_FRAME   = 20'd250000;
    localparam logic [SCALE_W-1:0]  RST_TIME_SCALE  = 11'd256;

    // Output item kinds.
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CIDX_W-1:0] {
        CFG_TICK_PERIOD = 8'd0,
        CFG_MAX_CATCHUP = 8'd1,
        CFG_MAX_FRAME   = 8'd2,
        CFG_TIME_SCALE  = 8'd3
    } t_cfg_idx;

    // Effective configuration after the special-value rules are applied.
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [CNT_W-1:0]    limit;
        logic [FRAME_W-1:0]  max_frame;
        logic [SCALE_W-1:0]  scale;
    } t_cfg;

    // Result of the shared compare and subtract unit.
    typedef struct packed {
        logic             ge;
        logic [ACC_W-1:0] diff;
    } t_sub_res;

endpackage

`default_nettype wire

// ----- src/ftts_sub_unit.sv -----
// Shared compare and subtract unit against the tick period.
`default_nettype none

module ftts_sub_unit (
    input  wire logic [ftts_pkg::ACC_W-1:0]    i_a,
    input  wire logic [ftts_pkg::PERIOD_W-1:0] i_period,
    output ftts_pkg::t_sub_res                 o_res
);
    import ftts_pkg::*;

    logic [ACC_W-1:0] w_period_ext;

    // One wide compare and subtract, used by the tick loop and both divisions.
    always_comb begin
        w_period_ext = {{(ACC_W-PERIOD_W){1'b0}}, i_period};
        o_res.ge     = (i_a >= w_period_ext);
        o_res.diff   = i_a - w_period_ext;
    end

endmodule

`default_nettype wire

// ----- src/ftts_cfg_regs.sv -----
// Configuration registers and their effective values.
`default_nettype none

module ftts_cfg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    input  wire logic                         i_cfg_ready,
    input  wire logic [ftts_pkg::CIDX_W-1:0]  i_cfg_index,
    input  wire logic [ftts_pkg::CDATA_W-1:0] i_cfg_data,
    output ftts_pkg::t_cfg                    o_cfg
);
    import ftts_pkg::*;

    logic [PERIOD_W-1:0] r_tick_period;
    logic [CNT_W-1:0]    r_max_catchup;
    logic [FRAME_W-1:0]  r_max_frame;
    logic [SCALE_W-1:0]  r_time_scale;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= RST_TICK_PERIOD;
            r_max_catchup <= RST_MAX_CATCHUP;
            r_max_frame   <= RST_MAX_FRAME;
            r_time_scale  <= RST_TIME_SCALE;
        end else if (i_cfg_valid && i_cfg_ready) begin
            case (i_cfg_index)
                CFG_TICK_PERIOD: r_tick_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_MAX_CATCHUP: r_max_catchup <= i_cfg_data[CNT_W-1:0];
                CFG_MAX_FRAME:   r_max_frame   <= i_cfg_data[FRAME_W-1:0];
                CFG_TIME_SCALE:  r_time_scale  <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero period acts as one, and scale and catch-up limit saturate.
    always_comb begin
        o_cfg.period    = (r_tick_period == '0) ? PERIOD_W'(1) : r_tick_period;
        o_cfg.limit     = ({1'b0, r_max_catchup} > MAX_TICKS) ?
                          MAX_TICKS[CNT_W-1:0] : r_max_catchup;
        o_cfg.max_frame = r_max_frame;
        o_cfg.scale     = (r_time_scale > SCALE_MAX) ? SCALE_MAX : r_time_scale;
    end

endmodule

`default_nettype wire

// ----- src/fixed_timestep_tick_scheduler_top.sv -----
// Fixed-timestep tick scheduler: sequencer around one shared compare/subtract unit.
// A paused frame emits its pending ticks; a running frame emits its ticks, then runs a
// bit-serial modulo of the 22-bit accumulator when backlog is dropped, and computes
// alpha with a 16-step restoring division on the unit.
// One frame is in work at a time; each result waits while the output is stalled.
// Synchronous active-low reset clears the accumulator, simulation time and pending steps.
`default_nettype none

module fixed_timestep_tick_scheduler_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Frame input channel.
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [31:0]                  i_frame_us,
    input  wire logic                                i_paused,
    input  wire logic [ftts_pkg::CNT_W-1:0]          i_new_steps,
    // Result output channel.
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_kind,
    output logic [ftts_pkg::STEP_W-1:0]              o_tick_sim_us,
    output logic [ftts_pkg::SIM_W-1:0]               o_sim_time_us,
    output logic [ftts_pkg::CNT_W-1:0]               o_ticks_in_frame,
    output logic [ftts_pkg::ALPHA_W-1:0]             o_alpha_q16,
    output logic                                     o_backlog_dropped,
    output logic [ftts_pkg::DROP_W-1:0]              o_dropped_us,
    output logic [ftts_pkg::FRAME_W-1:0]             o_clamped_us,
    output logic                                     o_last,
    // Configuration write channel.
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [ftts_pkg::CIDX_W-1:0]         i_cfg_index,
    input  wire logic [ftts_pkg::CDATA_W-1:0]        i_cfg_data
);
    import ftts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_TICK,
        S_MOD,
        S_MODFIN,
        S_ALPHA,
        S_SUM
    } t_state;

    localparam int PROD_W = PERIOD_W + SCALE_W;
    localparam logic [4:0] MOD_STEPS   = 5'(ACC_W - 1);
    localparam logic [4:0] ALPHA_STEPS = 5'd15;

    t_cfg     w_cfg;
    t_sub_res w_unit;

    t_state               r_state;
    logic [31:0]          r_raw;
    logic                 r_paused;
    logic [CNT_W-1:0]     r_add;
    logic [FRAME_W-1:0]   r_clamped;
    logic [STEP_W-1:0]    r_step;
    logic [CNT_W-1:0]     r_pend;
    logic [ACC_W-1:0]     r_acc;
    logic [CNT_W-1:0]     r_n;
    logic                 r_drop;
    logic [DROP_W-1:0]    r_dropped;
    logic [15:0]          r_alpha;
    logic [PERIOD_W-1:0]  r_rem;
    logic [ACC_W-1:0]     r_dvd;
    logic [4:0]           r_cnt;

    // Architectural state.
    logic [DROP_W-1:0]    r_accum;
    logic [SIM_W-1:0]     r_sim;
    logic [CNT_W-1:0]     r_pending;

    // Output register.
    logic                 r_out_valid;
    logic                 r_o_kind;
    logic [STEP_W-1:0]    r_o_tick;
    logic [SIM_W-1:0]     r_o_sim;
    logic [CNT_W-1:0]     r_o_ticks;
    logic [ALPHA_W-1:0]   r_o_alpha;
    logic                 r_o_drop;
    logic [DROP_W-1:0]    r_o_dropped;
    logic [FRAME_W-1:0]   r_o_clamped;
    logic                 r_o_last;

    logic [ACC_W-1:0]     w_unit_a;
    logic [FRAME_W-1:0]   w_clamped;
    logic [PROD_W-1:0]    w_prod;
    logic [CNT_W:0]       w_pend_sum;
    logic [CNT_W-1:0]     w_pend_sat;
    logic [ACC_W-1:0]     w_acc_sum;
    logic [PERIOD_W-1:0]  w_rem_step;
    logic [ACC_W-1:0]     w_drop_diff;
    logic [SIM_W-1:0]     w_sim_next;
    logic                 w_out_free;

    ftts_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Operand of the shared unit depends on the phase of the sequencer.
    always_comb begin
        case (r_state)
            S_MOD:   w_unit_a = {1'b0, r_rem, r_dvd[ACC_W-1]};
            S_ALPHA: w_unit_a = {1'b0, r_rem, 1'b0};
            default: w_unit_a = r_acc;
        endcase
    end

    ftts_sub_unit u_sub (
        .i_a      (w_unit_a),
        .i_period (w_cfg.period),
        .o_res    (w_unit)
    );

    // Per-frame setup values: clamp, scaled step, pending requests, new accumulator.
    always_comb begin
        if (r_raw[31]) begin
            w_clamped = '0;
        end else if (r_raw[30:0] > {{(31-FRAME_W){1'b0}}, w_cfg.max_frame}) begin
            w_clamped = w_cfg.max_frame;
        end else begin
            w_clamped = r_raw[FRAME_W-1:0];
        end
        w_prod      = {{SCALE_W{1'b0}}, w_cfg.period} * {{PERIOD_W{1'b0}}, w_cfg.scale};
        w_pend_sum  = {1'b0, r_pending} + {1'b0, r_add};
        w_pend_sat  = (w_pend_sum > MAX_TICKS) ? MAX_TICKS[CNT_W-1:0] : w_pend_sum[CNT_W-1:0];
        w_acc_sum   = {1'b0, r_accum} + {{(ACC_W-FRAME_W){1'b0}}, w_clamped};
        w_rem_step  = w_unit.ge ? w_unit.diff[PERIOD_W-1:0] : w_unit_a[PERIOD_W-1:0];
        w_drop_diff = r_acc - {{(ACC_W-PERIOD_W){1'b0}}, r_rem};
        w_sim_next  = r_sim + {{(SIM_W-STEP_W){1'b0}}, r_step};
        w_out_free  = !r_out_valid || !i_stall;
    end

    // Sequencer, state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_accum     <= '0;
            r_sim       <= '0;
            r_pending   <= '0;
        end else begin
            // The output register empties when its transfer completes.
            if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_raw    <= i_frame_us;
                        r_paused <= i_paused;
                        r_add    <= i_new_steps;
                        r_state  <= S_PREP;
                    end
                end

                S_PREP: begin
                    r_clamped <= w_clamped;
                    r_step    <= w_prod[STEP_W+7:8];
                    r_pend    <= w_pend_sat;
                    r_pending <= r_paused ? '0 : w_pend_sat;
                    r_acc     <= r_paused ? '0 : w_acc_sum;
                    r_n       <= '0;
                    r_drop    <= 1'b0;
                    r_dropped <= '0;
                    r_alpha   <= '0;
                    r_state   <= S_TICK;
                end

                S_TICK: begin
                    if (r_paused) begin
                        // Paused: run every pending step request.
                        if (r_pend == '0) begin
                            r_state <= S_SUM;
                        end else if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_o_kind    <= KIND_TICK;
                            r_o_tick    <= r_step;
                            r_o_sim     <= w_sim_next;
                            r_o_ticks   <= '0;
                            r_o_alpha   <= '0;
                            r_o_drop    <= 1'b0;
                            r_o_dropped <= '0;
                            r_o_clamped <= '0;
                            r_o_last    <= 1'b0;
                            r_sim       <= w_sim_next;
                            r_pend      <= r_pend - CNT_W'(1);
                            r_n         <= r_n + CNT_W'(1);
                        end
                    end else if (w_unit.ge && (r_n < w_cfg.limit)) begin
                        // Running: one tick per whole period up to the limit.
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_o_kind    <= KIND_TICK;
                            r_o_tick    <= r_step;
                            r_o_sim     <= w_sim_next;
                            r_o_ticks   <= '0;
                            r_o_alpha   <= '0;
                            r_o_drop    <= 1'b0;
                            r_o_dropped <= '0;
                            r_o_clamped <= '0;
                            r_o_last    <= 1'b0;
                            r_sim       <= w_sim_next;
                            r_acc       <= w_unit.diff;
                            r_n         <= r_n + CNT_W'(1);
                        end
                    end else if (w_unit.ge) begin
                        // Limit reached with backlog left: reduce it modulo the period.
                        r_rem   <= '0;
                        r_dvd   <= r_acc;
                        r_cnt   <= MOD_STEPS;
                        r_state <= S_MOD;
                    end else begin
                        r_accum <= r_acc[DROP_W-1:0];
                        r_rem   <= r_acc[PERIOD_W-1:0];
                        r_cnt   <= ALPHA_STEPS;
                        r_state <= S_ALPHA;
                    end
                end

                S_MOD: begin
                    // One remainder bit per cycle.
                    r_rem <= w_rem_step;
                    r_dvd <= {r_dvd[ACC_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        r_state <= S_MODFIN;
                    end
                end

                S_MODFIN: begin
                    r_drop    <= 1'b1;
                    r_dropped <= w_drop_diff[DROP_W-1:0];
                    r_acc     <= {{(ACC_W-PERIOD_W){1'b0}}, r_rem};
                    r_accum   <= {{(DROP_W-PERIOD_W){1'b0}}, r_rem};
                    r_cnt     <= ALPHA_STEPS;
                    r_state   <= S_ALPHA;
                end

                S_ALPHA: begin
                    // Restoring division of accumulator * 65536 by the period.
                    r_rem   <= w_rem_step;
                    r_alpha <= {r_alpha[14:0], w_unit.ge};
                    r_cnt   <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        r_state <= S_SUM;
                    end
                end

                S_SUM: begin
                    if (r_paused) begin
                        r_accum <= '0;
                    end
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_kind    <= KIND_SUMMARY;
                        r_o_tick    <= '0;
                        r_o_sim     <= r_sim;
                        r_o_ticks   <= r_n;
                        r_o_alpha   <= {1'b0, r_alpha};
                        r_o_drop    <= r_drop;
                        r_o_dropped <= r_dropped;
                        r_o_clamped <= r_clamped;
                        r_o_last    <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Port drive.
    assign o_stall           = (r_state != S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_valid           = r_out_valid;
    assign o_kind            = r_o_kind;
    assign o_tick_sim_us     = r_o_tick;
    assign o_sim_time_us     = r_o_sim;
    assign o_ticks_in_frame  = r_o_ticks;
    assign o_alpha_q16       = r_o_alpha;
    assign o_backlog_dropped = r_o_drop;
    assign o_dropped_us      = r_o_dropped;
    assign o_clamped_us      = r_o_clamped;
    assign o_last            = r_o_last;

endmodule

`default_nettype wire

// ----- tb/tb_fixed_timestep_tick_scheduler_top.sv -----
// Self-checking testbench for the fixed-timestep tick scheduler: directed frames, then random.
module tb_fixed_timestep_tick_scheduler_top;
    import ftts_pkg::*;

    // Register index that maps to no register; writes to it must be ignored.
    localparam logic [CIDX_W-1:0] CFG_UNMAPPED = 8'hFF;
    // Receiver hold-off used to fill the block up, in cycles.
    localparam int LONG_HOLD = 400;
    localparam int NUM_ROWS = 18;
    localparam int NUM_PHASES = 9;
    localparam int FRAMES_PER_PHASE = 40;

    // One result item as the block should present it.
    typedef struct packed {
        logic                kind;
        logic [STEP_W-1:0]   tick_sim_us;
        logic [SIM_W-1:0]    sim_time_us;
        logic [CNT_W-1:0]    ticks_in_frame;
        logic [ALPHA_W-1:0]  alpha_q16;
        logic                backlog_dropped;
        logic [DROP_W-1:0]   dropped_us;
        logic [FRAME_W-1:0]  clamped_us;
        logic                last;
    } t_sched_result;

    // One directed frame; when typed is set, the summary fields below are known by hand.
    typedef struct packed {
        logic [31:0]         frame_us;
        logic                paused;
        logic [CNT_W-1:0]    new_steps;
        logic                typed;
        logic [CNT_W-1:0]    ticks;
        logic [ALPHA_W-1:0]  alpha;
        logic [FRAME_W-1:0]  clamped;
    } t_frame_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   frame_valid = 1'b0;
    logic                   frame_stall;
    logic signed [31:0]     frame_us = '0;
    logic                   frame_paused = 1'b0;
    logic [CNT_W-1:0]       frame_steps = '0;

    logic                   res_valid;
    logic                   result_stall = 1'b0;
    logic                   res_kind;
    logic [STEP_W-1:0]      res_tick_sim_us;
    logic [SIM_W-1:0]       res_sim_time_us;
    logic [CNT_W-1:0]       res_ticks_in_frame;
    logic [ALPHA_W-1:0]     res_alpha_q16;
    logic                   res_backlog_dropped;
    logic [DROP_W-1:0]      res_dropped_us;
    logic [FRAME_W-1:0]     res_clamped_us;
    logic                   res_last;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CIDX_W-1:0]      cfg_index = '0;
    logic [CDATA_W-1:0]     cfg_data = '0;

    // Mirror of the configuration registers.
    logic [PERIOD_W-1:0]    period_cfg = RST_TICK_PERIOD;
    logic [CNT_W-1:0]       catchup_cfg = RST_MAX_CATCHUP;
    logic [FRAME_W-1:0]     frame_max_cfg = RST_MAX_FRAME;
    logic [SCALE_W-1:0]     scale_cfg = RST_TIME_SCALE;

    // Mirror of the scheduler state.
    logic [20:0]            acc_us = '0;
    logic [SIM_W-1:0]       sim_us = '0;
    logic [CNT_W-1:0]       steps_waiting = '0;

    t_sched_result          due_results[$];
    t_sched_result          want;
    int                     mismatch_count = 0;

    // Idling controls shared between the sender and the receiver.
    bit                     tx_gaps = 1'b1;
    bit                     rx_gaps = 1'b1;
    bit                     hold_req = 1'b0;
    bit                     hold_seen = 1'b0;
    int                     stall_left = 0;

    // Directed frames, starting from the reset configuration.
    //  frame_us        paused steps   typed ticks  alpha   clamped
    t_frame_row rows [0:NUM_ROWS-1] = '{
        {32'd0,          1'b0, 6'd0,  1'b1, 6'd0,  17'd0, 20'd0},
        {32'hFFFF_FFFF,  1'b0, 6'd0,  1'b1, 6'd0,  17'd0, 20'd0},
        {32'h8000_0000,  1'b0, 6'd0,  1'b1, 6'd0,  17'd0, 20'd0},
        {32'd16667,      1'b0, 6'd0,  1'b1, 6'd1,  17'd0, 20'd16667},
        {32'h7FFF_FFFF,  1'b0, 6'd0,  1'b0, 6'd0,  17'd0, 20'd0},
        {32'd5,          1'b0, 6'd0,  1'b0, 6'd0,  17'd0, 20'd0},
        {32'd1000,       1'b1, 6'd32, 1'b1, 6'd32, 17'd0, 20'd1000},
        {32'd0,          1'b0, 6'd63, 1'b1, 6'd0,  17'd0, 20'd0},
        {32'd0,          1'b1, 6'd0,  1'b1, 6'd32, 17'd0, 20'd0},
        {32'd8333,       1'b0, 6'd20, 1'b0, 6'd0,  17'd0, 20'd0},
        {32'd8334,       1'b0, 6'd20, 1'b0, 6'd0,  17'd0, 20'd0},
        {32'd250000,     1'b1, 6'd0,  1'b1, 6'd32, 17'd0, 20'd250000},
        {32'd250001,     1'b0, 6'd0,  1'b0, 6'd0,  17'd0, 20'd0},
        {32'd1,          1'b1, 6'd1,  1'b1, 6'd1,  17'd0, 20'd1},
        {32'd16666,      1'b0, 6'd0,  1'b0, 6'd0,  17'd0, 20'd0},
        {32'd1,          1'b0, 6'd0,  1'b0, 6'd0,  17'd0, 20'd0},
        {32'd16666,      1'b0, 6'd1,  1'b0, 6'd0,  17'd0, 20'd0},
        {32'd0,          1'b1, 6'd0,  1'b1, 6'd1,  17'd0, 20'd0}
    };

    fixed_timestep_tick_scheduler_top dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (frame_valid),
        .o_stall           (frame_stall),
        .i_frame_us        (frame_us),
        .i_paused          (frame_paused),
        .i_new_steps       (frame_steps),
        .o_valid           (res_valid),
        .i_stall           (result_stall),
        .o_kind            (res_kind),
        .o_tick_sim_us     (res_tick_sim_us),
        .o_sim_time_us     (res_sim_time_us),
        .o_ticks_in_frame  (res_ticks_in_frame),
        .o_alpha_q16       (res_alpha_q16),
        .o_backlog_dropped (res_backlog_dropped),
        .o_dropped_us      (res_dropped_us),
        .o_clamped_us      (res_clamped_us),
        .o_last            (res_last),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    // Free-running clock with a period of 10.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the ticks of one frame, queues them, and hands back the summary item.
    task automatic compute_frame_results(input logic [31:0] frame, input logic pause,
                                         input logic [CNT_W-1:0] steps,
                                         output t_sched_result summary);
        logic [PERIOD_W-1:0] per;
        logic [SCALE_W-1:0]  scl;
        logic [CNT_W:0]      lim;
        logic [CNT_W:0]      pend;
        logic [CNT_W:0]      n;
        logic [FRAME_W-1:0]  clamp;
        logic [31:0]         product;
        logic [STEP_W-1:0]   step;
        logic [22:0]         acc;
        logic [22:0]         rem;
        logic [38:0]         quotient;
        logic [ALPHA_W-1:0]  alpha;
        logic [22:0]         dropped;
        logic                drop;
        t_sched_result       tick;

        // Negative frame times clamp to zero, long ones to the frame limit.
        if (frame[31])
            clamp = '0;
        else if (frame > {12'd0, frame_max_cfg})
            clamp = frame_max_cfg;
        else
            clamp = frame[FRAME_W-1:0];

        // A zero period counts as one; scale and catch-up limit saturate.
        per = (period_cfg == '0) ? 20'd1 : period_cfg;
        scl = (scale_cfg > SCALE_MAX) ? SCALE_MAX : scale_cfg;
        lim = (catchup_cfg > MAX_TICKS) ? MAX_TICKS : {1'b0, catchup_cfg};
        product = per * scl;
        step = product[29:8];

        // Step requests pile up to the tick limit.
        pend = {1'b0, steps_waiting} + {1'b0, steps};
        if (pend > MAX_TICKS)
            pend = MAX_TICKS;

        tick = '0;
        tick.kind = KIND_TICK;
        tick.tick_sim_us = step;
        n = '0;
        alpha = '0;
        dropped = '0;
        drop = 1'b0;

        if (pause) begin
            // Paused: all step requests run and the accumulator is cleared.
            acc = '0;
            while (pend != '0) begin
                sim_us = sim_us + step;
                tick.sim_time_us = sim_us;
                due_results.push_back(tick);
                n = n + 1'b1;
                pend = pend - 1'b1;
            end
        end else begin
            // Running: one tick per whole period, then drop backlog past the limit.
            acc = {2'b00, acc_us} + clamp;
            while (acc >= per && n < lim) begin
                sim_us = sim_us + step;
                tick.sim_time_us = sim_us;
                due_results.push_back(tick);
                n = n + 1'b1;
                acc = acc - per;
            end
            if (n == lim && acc >= per) begin
                rem = acc % per;
                dropped = acc - rem;
                drop = 1'b1;
                acc = rem;
            end
            quotient = {acc, 16'd0} / per;
            alpha = (quotient > 39'd65536) ? 17'd65536 : quotient[ALPHA_W-1:0];
        end

        acc_us = acc[20:0];
        steps_waiting = pend[CNT_W-1:0];

        summary = '0;
        summary.kind = KIND_SUMMARY;
        summary.sim_time_us = sim_us;
        summary.ticks_in_frame = n[CNT_W-1:0];
        summary.alpha_q16 = alpha;
        summary.backlog_dropped = drop;
        summary.dropped_us = dropped[DROP_W-1:0];
        summary.clamped_us = clamp;
        summary.last = 1'b1;
    endtask

    // Offers one frame, with an optional idle burst first, and predicts it once transferred.
    task automatic send_frame(input logic [31:0] frame, input logic pause,
                              input logic [CNT_W-1:0] steps, input logic typed,
                              input logic [CNT_W-1:0] typed_ticks,
                              input logic [ALPHA_W-1:0] typed_alpha,
                              input logic [FRAME_W-1:0] typed_clamp);
        t_sched_result summary;

        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            frame_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame_us <= frame;
        frame_paused <= pause;
        frame_steps <= steps;
        do @(posedge clk); while (frame_stall);

        compute_frame_results(frame, pause, steps, summary);
        // Hand-derived values take the place of the computed ones.
        if (typed) begin
            summary.ticks_in_frame = typed_ticks;
            summary.alpha_q16 = typed_alpha;
            summary.clamped_us = typed_clamp;
        end
        due_results.push_back(summary);
    endtask

    // Holds the frame input idle until every expected result has come out.
    task automatic wait_drained();
        frame_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write transfer; the caller lowers the valid after its last write.
    task automatic write_register(input logic [CIDX_W-1:0] idx,
                                  input logic [CDATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_TICK_PERIOD: period_cfg = data[PERIOD_W-1:0];
            CFG_MAX_CATCHUP: catchup_cfg = data[CNT_W-1:0];
            CFG_MAX_FRAME:   frame_max_cfg = data[FRAME_W-1:0];
            CFG_TIME_SCALE:  scale_cfg = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_settings(input logic [CDATA_W-1:0] per,
                                    input logic [CDATA_W-1:0] catchup,
                                    input logic [CDATA_W-1:0] frame_max,
                                    input logic [CDATA_W-1:0] scale);
        write_register(CFG_TICK_PERIOD, per);
        write_register(CFG_MAX_CATCHUP, catchup);
        write_register(CFG_MAX_FRAME, frame_max);
        write_register(CFG_TIME_SCALE, scale);
        cfg_valid <= 1'b0;
    endtask

    // Random frame time, weighted toward values that produce ticks and backlog.
    function automatic logic [31:0] rand_frame_time();
        logic [31:0] eff_per;

        eff_per = (period_cfg == '0) ? 32'd1 : {12'd0, period_cfg};
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom() | 32'h8000_0000;
            2: return $urandom_range(0, frame_max_cfg + 2);
            3: return $urandom_range(0, (catchup_cfg + 2) * eff_per);
            default: return $urandom_range(0, 3 * eff_per);
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] rand_steps();
        case ($urandom_range(0, 9))
            7, 8: return CNT_W'($urandom_range(1, 4));
            9: return CNT_W'($urandom_range(0, 63));
            default: return '0;
        endcase
    endfunction

    // Result channel stall: random bursts, plus one long hold-off on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            result_stall <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            stall_left = LONG_HOLD - 1;
            result_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            result_stall <= 1'b1;
        end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            result_stall <= 1'b1;
        end else begin
            result_stall <= 1'b0;
        end
    end

    function automatic void check_field(input string name, input logic [SIM_W-1:0] exp_val,
                                        input logic [SIM_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    // Every result transfer is compared with the oldest expected item.
    always @(posedge clk) begin
        if (rst_n && res_valid && !result_stall) begin
            if (due_results.size() == 0) begin
                $display("%0t: result transfer with nothing expected, kind %0d",
                         $time, res_kind);
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                check_field("kind", SIM_W'(want.kind), SIM_W'(res_kind));
                check_field("tick_sim_us", SIM_W'(want.tick_sim_us),
                            SIM_W'(res_tick_sim_us));
                check_field("sim_time_us", want.sim_time_us, res_sim_time_us);
                check_field("ticks_in_frame", SIM_W'(want.ticks_in_frame),
                            SIM_W'(res_ticks_in_frame));
                check_field("alpha_q16", SIM_W'(want.alpha_q16), SIM_W'(res_alpha_q16));
                check_field("backlog_dropped", SIM_W'(want.backlog_dropped),
                            SIM_W'(res_backlog_dropped));
                check_field("dropped_us", SIM_W'(want.dropped_us), SIM_W'(res_dropped_us));
                check_field("clamped_us", SIM_W'(want.clamped_us), SIM_W'(res_clamped_us));
                check_field("last", SIM_W'(want.last), SIM_W'(res_last));
            end
        end
    end

    // Main sequence: reset, directed frames, then random phases under varied settings.
    initial begin
        int row;
        int phase;
        int k;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < NUM_ROWS; row++)
            send_frame(rows[row].frame_us, rows[row].paused, rows[row].new_steps,
                       rows[row].typed, rows[row].ticks, rows[row].alpha,
                       rows[row].clamped);
        wait_drained();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    // Zero period, catch-up and scale above their ceilings.
                    write_register(CFG_UNMAPPED, 20'hFFFFF);
                    program_settings(20'd0, 20'd63, 20'd1000000, 20'd2047);
                end
                1: program_settings(20'hFFFFF, 20'd0, 20'hFFFFF, 20'd0);
                2: program_settings(20'd1, 20'd1, 20'd1, 20'd1024);
                3: program_settings(20'd1000000, 20'd32, 20'd0, 20'd1);
                default: begin
                    program_settings(($urandom_range(0, 3) == 0) ?
                                         20'($urandom_range(0, 20'hFFFFF)) :
                                         20'($urandom_range(1, 40000)),
                                     {14'($urandom_range(0, 16383)),
                                      6'($urandom_range(0, 63))},
                                     20'($urandom_range(0, 20'hFFFFF)),
                                     {9'($urandom_range(0, 511)),
                                      11'($urandom_range(0, 2047))});
                end
            endcase

            // Phase 5 stalls results for a long stretch while frames keep coming.
            if (phase == 5)
                hold_req = ~hold_req;
            tx_gaps = (phase != 5) && (phase != NUM_PHASES - 1);
            rx_gaps = (phase != NUM_PHASES - 1);

            for (k = 0; k < FRAMES_PER_PHASE; k++) begin
                if (phase == 2 && k == FRAMES_PER_PHASE / 2)
                    wait_drained();
                send_frame(rand_frame_time(), $urandom_range(0, 4) == 0, rand_steps(),
                           1'b0, '0, '0, '0);
            end
            wait_drained();
        end

        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(10 * 1500000);
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- fixed_timestep_tick_scheduler_top.f -----
src/ftts_pkg.sv
src/ftts_sub_unit.sv
src/ftts_cfg_regs.sv
src/fixed_timestep_tick_scheduler_top.sv
tb/tb_fixed_timestep_tick_scheduler_top.sv
